// ===== hdl/stlc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor telemetry link controller package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package stlc_pkg;

  localparam int unsigned HISTORY_DEPTH = 10;
  localparam int unsigned RING_AW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned PTR_W         = $clog2(HISTORY_DEPTH + 1);

  localparam logic       MODE_TICK = 1'b0;
  localparam logic       MODE_CMD  = 1'b1;

  localparam logic [7:0] CMD_ACK     = 8'h06;
  localparam logic [7:0] CMD_INT1    = 8'h31;
  localparam logic [7:0] CMD_INT4    = 8'h34;
  localparam logic [7:0] CMD_RESET   = 8'h72;
  localparam logic [7:0] CMD_START   = 8'h64;
  localparam logic [7:0] CMD_STOP    = 8'h71;
  localparam logic [7:0] CMD_FAN_ON  = 8'h65;
  localparam logic [7:0] CMD_FAN_OFF = 8'h61;
  localparam logic [7:0] CMD_STATUS  = 8'h73;

  localparam logic [2:0] INTERVAL_1  = 3'd1;
  localparam logic [2:0] INTERVAL_4  = 3'd4;
  localparam logic [1:0] RETRY_LIMIT = 2'd3;
  localparam logic [7:0] SEQ_RESET   = 8'd1;

  typedef enum logic [1:0] {
    FRAME_NONE = 2'd0,
    FRAME_DATA = 2'd1,
    FRAME_FAN  = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic take;
    logic step;
  } stlc_cmd_t;

  typedef struct packed {
    logic replay;
    logic last_rec;
  } stlc_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sensor_telemetry_link_controller.sv =====
// ----------------------------------------------------------------------------
// Sensor telemetry link controller
// Usage:
//   The slave stream carries second ticks (tuser 0, sensor reading in tdata)
//   and received command bytes (tuser 1, byte in tdata). The master stream
//   returns result items: a data record, a fan report or an empty item, with
//   tuser giving the frame kind and tlast marking the final item of an input.
//   Each result carries the link status after the input was handled.
//   The first result is registered and valid in the cycle after the input
//   is taken. One input at a time: tready drops from the accept until the
//   last result is taken. An acknowledge after link loss replays the ten
//   ring records from the output register, one per cycle while the
//   receiver is ready.
//   A stalled receiver holds the result register and its tvalid; nothing is
//   dropped. Reset clears the link state and the history ring at once, with
//   the sequence number at 1 and the interval at one second.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_telemetry_link_controller (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // command_byte, sensor_ok, temperature_in, humidity_in
  input  wire  [0:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // temperature_out, humidity_out, sequence_out, fan_on,
                                      // status_led, link_lost, sending_enabled,
                                      // interval_seconds
  output logic [1:0]  m_axis_tuser,   // frame_kind
  output logic        m_axis_tlast
);

  stlc_pkg::stlc_cmd_t  cmd;
  stlc_pkg::stlc_stat_t stat;

  logic [7:0] temperature_out;
  logic [7:0] humidity_out;
  logic [7:0] sequence_out;
  logic       fan_on;
  logic       status_led;
  logic       link_lost;
  logic       sending_enabled;
  logic [2:0] interval_seconds;

  stlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stlc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .mode_i             (s_axis_tuser[0]),
    .command_byte_i     (s_axis_tdata[7:0]),
    .sensor_ok_i        (s_axis_tdata[8]),
    .temperature_in_i   (s_axis_tdata[16:9]),
    .humidity_in_i      (s_axis_tdata[24:17]),
    .frame_kind_o       (m_axis_tuser),
    .temperature_out_o  (temperature_out),
    .humidity_out_o     (humidity_out),
    .sequence_out_o     (sequence_out),
    .last_o             (m_axis_tlast),
    .fan_on_o           (fan_on),
    .status_led_o       (status_led),
    .link_lost_o        (link_lost),
    .sending_enabled_o  (sending_enabled),
    .interval_seconds_o (interval_seconds)
  );

  assign m_axis_tdata = {1'b0, interval_seconds, sending_enabled, link_lost, status_led,
                         fan_on, sequence_out, humidity_out, temperature_out};

endmodule

`default_nettype wire

// ===== hdl/stlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sensor telemetry link controller sequencer
// Handshake control: takes an item, then delivers one result or a replay run.
// ----------------------------------------------------------------------------
`default_nettype none

module stlc_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  input  wire stlc_pkg::stlc_stat_t stat_i,
  output stlc_pkg::stlc_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_REPLAY
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.take = in_valid_i & in_ready_q;
    cmd_o.step = out_valid_q & out_ready_i & (state_q == ST_REPLAY) & ~stat_i.last_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= stat_i.replay ? ST_REPLAY : ST_SINGLE;
          end
        end
        ST_SINGLE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_REPLAY: begin
          if (out_ready_i && stat_i.last_rec) begin
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stlc_dp.sv =====
// ----------------------------------------------------------------------------
// Sensor telemetry link controller datapath
// Link state, history ring and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stlc_dp (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire stlc_pkg::stlc_cmd_t cmd_i,
  output stlc_pkg::stlc_stat_t     stat_o,
  input  wire                      mode_i,
  input  wire  [7:0]               command_byte_i,
  input  wire                      sensor_ok_i,
  input  wire  [7:0]               temperature_in_i,
  input  wire  [7:0]               humidity_in_i,
  output logic [1:0]               frame_kind_o,
  output logic [7:0]               temperature_out_o,
  output logic [7:0]               humidity_out_o,
  output logic [7:0]               sequence_out_o,
  output logic                     last_o,
  output logic                     fan_on_o,
  output logic                     status_led_o,
  output logic                     link_lost_o,
  output logic                     sending_enabled_o,
  output logic [2:0]               interval_seconds_o
);

  localparam logic [stlc_pkg::PTR_W-1:0]   PtrDepth =
    stlc_pkg::PTR_W'(stlc_pkg::HISTORY_DEPTH);
  localparam logic [stlc_pkg::RING_AW-1:0] LastPos  =
    stlc_pkg::RING_AW'(stlc_pkg::HISTORY_DEPTH - 1);
  localparam logic [7:0]                   SeqDepth = 8'(stlc_pkg::HISTORY_DEPTH);

  logic [2:0]  tick_q, tick_d;
  logic [2:0]  interval_q, interval_d;
  logic        send_q, send_d;
  logic [7:0]  seq_q, seq_d;
  logic [1:0]  retry_q, retry_d;
  logic        lost_q, lost_d;
  logic        fan_q, fan_d;
  logic        led_q, led_d;
  logic [stlc_pkg::PTR_W-1:0] ptr_q, ptr_d;
  logic [7:0]  stored_q, stored_d;
  logic [15:0] ring_q [stlc_pkg::HISTORY_DEPTH];

  logic [1:0]  kind_q, kind_d;
  logic [7:0]  tout_q, hout_q, sout_q;
  logic        last_q;
  logic [stlc_pkg::RING_AW-1:0] idx_q;
  logic [stlc_pkg::RING_AW-1:0] rpos_q;

  logic [stlc_pkg::RING_AW-1:0] wr_pos;
  logic [stlc_pkg::RING_AW-1:0] rpos_nxt;
  logic [stlc_pkg::RING_AW-1:0] rd_addr;
  logic [stlc_pkg::RING_AW-1:0] idx_nxt;
  logic [2:0]  tick_inc;
  logic [7:0]  seq0;
  logic        store_en;
  logic        replay;

  assign wr_pos   = (ptr_q >= PtrDepth) ? '0 : ptr_q[stlc_pkg::RING_AW-1:0];
  assign rpos_nxt = (rpos_q == LastPos) ? '0 : rpos_q + 1'b1;
  assign idx_nxt  = idx_q + 1'b1;
  assign rd_addr  = cmd_i.take ? wr_pos : rpos_nxt;
  assign tick_inc = tick_q + 3'd1;
  assign seq0     = (stored_q > SeqDepth) ? stored_q - SeqDepth : 8'd0;
  assign replay   = (mode_i == stlc_pkg::MODE_CMD) && (command_byte_i == stlc_pkg::CMD_ACK)
                    && lost_q;

  assign stat_o.replay   = replay;
  assign stat_o.last_rec = last_q;

  always_comb begin
    tick_d     = tick_q;
    interval_d = interval_q;
    send_d     = send_q;
    seq_d      = seq_q;
    retry_d    = retry_q;
    lost_d     = lost_q;
    fan_d      = fan_q;
    led_d      = led_q;
    ptr_d      = ptr_q;
    stored_d   = stored_q;
    kind_d     = stlc_pkg::FRAME_NONE;
    store_en   = 1'b0;
    if (mode_i == stlc_pkg::MODE_CMD) begin
      case (command_byte_i)
        stlc_pkg::CMD_ACK: begin
          lost_d  = 1'b0;
          led_d   = 1'b0;
          seq_d   = seq_q + 8'd1;
          retry_d = 2'd0;
        end
        stlc_pkg::CMD_INT1: begin
          interval_d = stlc_pkg::INTERVAL_1;
          tick_d     = 3'd0;
        end
        stlc_pkg::CMD_INT4: begin
          interval_d = stlc_pkg::INTERVAL_4;
          tick_d     = 3'd0;
        end
        stlc_pkg::CMD_RESET: begin
          retry_d = 2'd0;
          lost_d  = 1'b0;
          led_d   = 1'b0;
          send_d  = 1'b1;
        end
        stlc_pkg::CMD_START: begin
          send_d  = 1'b1;
          retry_d = 2'd0;
        end
        stlc_pkg::CMD_STOP: begin
          send_d = 1'b0;
          fan_d  = 1'b0;
        end
        stlc_pkg::CMD_FAN_ON:  fan_d = 1'b1;
        stlc_pkg::CMD_FAN_OFF: fan_d = 1'b0;
        stlc_pkg::CMD_STATUS:  kind_d = stlc_pkg::FRAME_FAN;
        default: ;
      endcase
    end else begin
      tick_d = tick_inc;
      if (tick_inc >= interval_q) begin
        tick_d = 3'd0;
        if (sensor_ok_i) begin
          store_en = 1'b1;
          ptr_d    = stlc_pkg::PTR_W'(wr_pos) + 1'b1;
          stored_d = seq_q;
          if (send_q) begin
            if (retry_q < stlc_pkg::RETRY_LIMIT) begin
              kind_d  = stlc_pkg::FRAME_DATA;
              retry_d = retry_q + 2'd1;
            end else begin
              led_d  = 1'b1;
              lost_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= 3'd0;
      interval_q <= stlc_pkg::INTERVAL_1;
      send_q     <= 1'b0;
      seq_q      <= stlc_pkg::SEQ_RESET;
      retry_q    <= 2'd0;
      lost_q     <= 1'b0;
      fan_q      <= 1'b0;
      led_q      <= 1'b0;
      ptr_q      <= '0;
      stored_q   <= 8'd0;
      last_q     <= 1'b0;
      idx_q      <= '0;
      rpos_q     <= '0;
      for (int i = 0; i < stlc_pkg::HISTORY_DEPTH; i++) begin
        ring_q[i] <= 16'd0;
      end
    end else if (cmd_i.take) begin
      tick_q     <= tick_d;
      interval_q <= interval_d;
      send_q     <= send_d;
      seq_q      <= seq_d;
      retry_q    <= retry_d;
      lost_q     <= lost_d;
      fan_q      <= fan_d;
      led_q      <= led_d;
      ptr_q      <= ptr_d;
      stored_q   <= stored_d;
      if (store_en) begin
        ring_q[wr_pos] <= {humidity_in_i, temperature_in_i};
      end
      idx_q  <= '0;
      rpos_q <= wr_pos;
      last_q <= ~replay;
    end else if (cmd_i.step) begin
      idx_q  <= idx_nxt;
      rpos_q <= rpos_nxt;
      last_q <= (idx_nxt == LastPos);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      if (replay) begin
        kind_q <= stlc_pkg::FRAME_DATA;
        tout_q <= ring_q[rd_addr][7:0];
        hout_q <= ring_q[rd_addr][15:8];
        sout_q <= seq0;
      end else begin
        kind_q <= kind_d;
        tout_q <= (kind_d == stlc_pkg::FRAME_DATA) ? temperature_in_i : 8'd0;
        hout_q <= (kind_d == stlc_pkg::FRAME_DATA) ? humidity_in_i : 8'd0;
        sout_q <= (kind_d == stlc_pkg::FRAME_DATA) ? seq_q : 8'd0;
      end
    end else if (cmd_i.step) begin
      tout_q <= ring_q[rd_addr][7:0];
      hout_q <= ring_q[rd_addr][15:8];
      sout_q <= sout_q + 8'd1;
    end
  end

  assign frame_kind_o       = kind_q;
  assign temperature_out_o  = tout_q;
  assign humidity_out_o     = hout_q;
  assign sequence_out_o     = sout_q;
  assign last_o             = last_q;
  assign fan_on_o           = fan_q;
  assign status_led_o       = led_q;
  assign link_lost_o        = lost_q;
  assign sending_enabled_o  = send_q;
  assign interval_seconds_o = interval_q;

endmodule

`default_nettype wire
